>>> rtl/mned_pkg.sv
// Shared types and constants for the MIDI note echo delay block.
// No dependencies; used by every module under rtl.
package mned_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 64;
    localparam int TICK_W      = $clog2(MAX_RESULTS + 1);
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

    localparam logic [13:0] MAX_BLOCK   = 14'd8192;
    localparam logic [7:0]  CMD_MASK    = 8'hf0;
    localparam logic [7:0]  CMD_NOTEOFF = 8'h80;
    localparam logic [7:0]  CMD_NOTEON  = 8'h90;
    localparam logic [6:0]  VEL_MAX     = 7'd127;
    localparam logic [9:0]  NOTE_LIMIT  = 10'd128;
    localparam logic [7:0]  OCTAVE      = 8'd12;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [1:0] CFG_LAG       = 2'd0;
    localparam logic [1:0] CFG_TRANSPOSE = 2'd1;
    localparam logic [1:0] CFG_GAIN      = 2'd2;

    localparam logic [11:0] GAIN_UNITY = 12'd256;

    typedef enum logic [1:0] {
        CMD_EVENT = 2'd0,
        CMD_ROLL  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [31:0] time_val;
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [13:0] length;
    } t_cmd;

    typedef struct packed {
        logic [31:0] time_val;
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  velocity;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cmdq_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_cmdq_stat;

endpackage

>>> rtl/midi_note_echo_delay_top.sv
// Top level of the MIDI note echo delay block.
// Depends on mned_pkg, mned_front, mned_cmdq and mned_back.
//
// Items are taken with start while busy is low and pass through a capture
// stage into a four-entry command queue; results appear on o_valid for one
// cycle each and cannot be held off. A MIDI event or stop is pushed into the
// command queue in the cycle after acceptance and carried out when the back
// part is idle and pops it; a drop report for a full echo queue is registered
// from the idle state. A block tick holds the back part while it drains the
// echo queue, passing through a wait and a check state for each emitted
// event, paced by the registered read port of the echo queue memory; its
// last result is strobed in the cycle after the head outside the window, the
// result limit or an empty echo queue is seen. Busy rises for one cycle after
// each item and stays high while the command queue is full.
module midi_note_echo_delay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_note_in,
    input  logic [6:0]  i_velocity_in,
    input  logic [31:0] i_event_time,
    input  logic [31:0] i_block_start,
    input  logic [13:0] i_block_length,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_result_kind,
    output logic [12:0] o_frame_offset,
    output logic [7:0]  o_status_out,
    output logic [6:0]  o_note_out,
    output logic [6:0]  o_velocity_out,
    output logic        o_last_of_run
);

    mned_pkg::t_cmd       front_cmd;
    mned_pkg::t_cmd       back_cmd;
    mned_pkg::t_cmdq_ctl  q_ctl;
    mned_pkg::t_cmdq_stat q_stat;
    logic                 push;
    logic                 pop;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    mned_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_opcode       (i_opcode),
        .i_status_byte  (i_status_byte),
        .i_note_in      (i_note_in),
        .i_velocity_in  (i_velocity_in),
        .i_event_time   (i_event_time),
        .i_block_start  (i_block_start),
        .i_block_length (i_block_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_stat.full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    mned_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_cmd   (front_cmd),
        .o_cmd   (back_cmd),
        .o_stat  (q_stat)
    );

    mned_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (back_cmd),
        .i_q_empty      (q_stat.empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_frame_offset (o_frame_offset),
        .o_status_out   (o_status_out),
        .o_note_out     (o_note_out),
        .o_velocity_out (o_velocity_out),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

>>> rtl/mned_cmdq.sv
// Short command queue between the front and back parts of the echo block.
// Depends on mned_pkg for the command type and depth.
module mned_cmdq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mned_pkg::t_cmdq_ctl i_ctl,
    input  mned_pkg::t_cmd      i_cmd,
    output mned_pkg::t_cmd      o_cmd,
    output mned_pkg::t_cmdq_stat o_stat
);

    mned_pkg::t_cmd                    r_mem [mned_pkg::CMDQ_DEPTH];
    logic [mned_pkg::CMDQ_AW-1:0]      r_wr_ptr;
    logic [mned_pkg::CMDQ_AW-1:0]      r_rd_ptr;
    logic [mned_pkg::CMDQ_CW-1:0]      r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == mned_pkg::CMDQ_CW'(mned_pkg::CMDQ_DEPTH));
    assign do_push      = i_ctl.push && !o_stat.full;
    assign do_pop       = i_ctl.pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == mned_pkg::CMDQ_AW'(mned_pkg::CMDQ_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == mned_pkg::CMDQ_AW'(mned_pkg::CMDQ_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + mned_pkg::CMDQ_CW'(do_push) - mned_pkg::CMDQ_CW'(do_pop);
        end
    end

endmodule

>>> rtl/mned_front.sv
// Front part: configuration registers, item capture and classification.
// Depends on mned_pkg; feeds classified commands to mned_cmdq.
module mned_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_status_byte,
    input  logic [6:0]            i_note_in,
    input  logic [6:0]            i_velocity_in,
    input  logic [31:0]           i_event_time,
    input  logic [31:0]           i_block_start,
    input  logic [13:0]           i_block_length,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output mned_pkg::t_cmd        o_cmd
);

    logic [23:0]        r_lag;
    logic signed [7:0]  r_transpose;
    logic [11:0]        r_gain;

    logic               r_stage_valid;
    logic [1:0]         r_opcode;
    logic [7:0]         r_status;
    logic [6:0]         r_note;
    logic [6:0]         r_vel;
    logic [31:0]        r_event_time;
    logic [31:0]        r_block_start;
    logic [13:0]        r_block_length;

    logic signed [9:0]  note_sum;
    logic [7:0]         wrap_mag;
    logic [15:0]        wrap_prod;
    logic [4:0]         wrap_k;
    logic [7:0]         wrap_step;
    logic [9:0]         note_fixed;
    logic [18:0]        vel_prod;
    logic [10:0]        vel_scaled;
    logic [7:0]         cmd_nib;
    logic               accept;

    assign accept = i_start && !o_busy;
    assign o_busy = r_stage_valid || i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag       <= '0;
            r_transpose <= '0;
            r_gain      <= mned_pkg::GAIN_UNITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mned_pkg::CFG_LAG:       r_lag       <= i_cfg_data;
                mned_pkg::CFG_TRANSPOSE: r_transpose <= i_cfg_data[7:0];
                mned_pkg::CFG_GAIN:      r_gain      <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (accept) begin
            r_stage_valid <= 1'b1;
        end else if (r_stage_valid && !i_q_full) begin
            r_stage_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode       <= i_opcode;
            r_status       <= i_status_byte;
            r_note         <= i_note_in;
            r_vel          <= i_velocity_in;
            r_event_time   <= i_event_time;
            r_block_start  <= i_block_start;
            r_block_length <= i_block_length;
        end
    end

    always_comb begin
        note_sum = signed'({3'b000, r_note}) + 10'(r_transpose);
        if (note_sum < 0) begin
            wrap_mag = 8'(-note_sum);
        end else begin
            wrap_mag = 8'(note_sum - 10'sd127);
        end
        wrap_prod = 16'(wrap_mag + 8'd11) * 16'd171;
        wrap_k    = wrap_prod[15:11];
        wrap_step = 8'(wrap_k * mned_pkg::OCTAVE);
        if (note_sum < 0) begin
            note_fixed = 10'(note_sum) + {2'b00, wrap_step};
        end else if (10'(note_sum) >= mned_pkg::NOTE_LIMIT) begin
            note_fixed = 10'(note_sum) - {2'b00, wrap_step};
        end else begin
            note_fixed = 10'(note_sum);
        end
        vel_prod   = 19'(r_vel) * 19'(r_gain);
        vel_scaled = vel_prod[18:8];
        cmd_nib    = r_status & mned_pkg::CMD_MASK;

        o_cmd.time_val = r_event_time + {8'b0, r_lag};
        o_cmd.status   = r_status;
        o_cmd.note     = note_fixed[6:0];
        o_cmd.velocity = (vel_scaled > 11'(mned_pkg::VEL_MAX)) ? mned_pkg::VEL_MAX :
                         vel_scaled[6:0];
        o_cmd.length   = (r_block_length > mned_pkg::MAX_BLOCK) ? mned_pkg::MAX_BLOCK :
                         r_block_length;
        o_cmd.op       = mned_pkg::CMD_ROLL;
        o_push         = r_stage_valid && !i_q_full;
        case (r_opcode)
            mned_pkg::OP_EVENT: begin
                if (cmd_nib == mned_pkg::CMD_NOTEOFF || cmd_nib == mned_pkg::CMD_NOTEON) begin
                    o_cmd.op = mned_pkg::CMD_EVENT;
                end
            end
            mned_pkg::OP_TICK: begin
                o_cmd.op       = mned_pkg::CMD_TICK;
                o_cmd.time_val = r_block_start;
            end
            mned_pkg::OP_STOP: o_cmd.op = mned_pkg::CMD_STOP;
            default: o_push = 1'b0;
        endcase
    end

endmodule

>>> rtl/mned_back.sv
// Back part: echo queue memory, transport state and block drain sequencer.
// Depends on mned_pkg; pops commands from mned_cmdq and drives the results.
module mned_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mned_pkg::t_cmd        i_cmd,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic                  o_result_kind,
    output logic [12:0]           o_frame_offset,
    output logic [7:0]            o_status_out,
    output logic [6:0]            o_note_out,
    output logic [6:0]            o_velocity_out,
    output logic                  o_last_of_run
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WAIT  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    mned_pkg::t_entry                r_mem [mned_pkg::QUEUE_DEPTH];
    mned_pkg::t_entry                r_rdata;

    t_state                          r_state, n_state;
    logic [mned_pkg::QUEUE_AW-1:0]   r_head, n_head;
    logic [mned_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_stopped, n_stopped;
    logic [mned_pkg::TICK_W-1:0]     r_ntick, n_ntick;
    logic [31:0]                     r_start, n_start;
    logic [13:0]                     r_len, n_len;
    logic                            r_pend, n_pend;
    mned_pkg::t_entry                r_pend_e, n_pend_e;
    logic [12:0]                     r_pend_off, n_pend_off;

    logic                            r_out_valid, n_out_valid;
    logic                            r_out_kind, n_out_kind;
    logic [12:0]                     r_out_off, n_out_off;
    mned_pkg::t_entry                r_out_e, n_out_e;
    logic                            r_out_last, n_out_last;

    logic                            mem_we;
    logic [mned_pkg::QUEUE_AW-1:0]   wr_addr;
    logic [mned_pkg::CNT_W:0]        wr_sum;
    mned_pkg::t_entry                wr_entry;
    logic [31:0]                     off;
    logic                            hit;

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_frame_offset = r_out_off;
    assign o_status_out   = r_out_e.status;
    assign o_note_out     = r_out_e.note;
    assign o_velocity_out = r_out_e.velocity;
    assign o_last_of_run  = r_out_last;

    assign wr_entry.time_val = i_cmd.time_val;
    assign wr_entry.status   = i_cmd.status;
    assign wr_entry.note     = i_cmd.note;
    assign wr_entry.velocity = i_cmd.velocity;

    always_comb begin
        wr_sum = (mned_pkg::CNT_W + 1)'(r_head) + (mned_pkg::CNT_W + 1)'(r_count);
        if (wr_sum >= (mned_pkg::CNT_W + 1)'(mned_pkg::QUEUE_DEPTH)) begin
            wr_sum = wr_sum - (mned_pkg::CNT_W + 1)'(mned_pkg::QUEUE_DEPTH);
        end
        wr_addr = wr_sum[mned_pkg::QUEUE_AW-1:0];
    end

    assign off = r_rdata.time_val - r_start;
    assign hit = (r_count != '0) &&
                 (r_ntick < mned_pkg::TICK_W'(mned_pkg::MAX_RESULTS)) &&
                 (off < {18'b0, r_len});

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_stopped   = r_stopped;
        n_ntick     = r_ntick;
        n_start     = r_start;
        n_len       = r_len;
        n_pend      = r_pend;
        n_pend_e    = r_pend_e;
        n_pend_off  = r_pend_off;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_off   = r_out_off;
        n_out_e     = r_out_e;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        mned_pkg::CMD_EVENT: begin
                            n_stopped = 1'b0;
                            if (r_count >= mned_pkg::CNT_W'(mned_pkg::QUEUE_DEPTH)) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = 1'b1;
                                n_out_off   = '0;
                                n_out_e     = wr_entry;
                                n_out_last  = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        mned_pkg::CMD_ROLL: n_stopped = 1'b0;
                        mned_pkg::CMD_TICK: begin
                            n_stopped = 1'b0;
                            n_start   = i_cmd.time_val;
                            n_len     = i_cmd.length;
                            n_ntick   = '0;
                            n_pend    = 1'b0;
                            n_state   = S_WAIT;
                        end
                        mned_pkg::CMD_STOP: begin
                            if (!r_stopped) begin
                                n_head  = '0;
                                n_count = '0;
                            end
                            n_stopped = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_WAIT: n_state = S_CHECK;
            S_CHECK: begin
                if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_off   = r_pend_off;
                    n_out_e     = r_pend_e;
                    n_out_last  = !hit;
                end
                if (hit) begin
                    n_pend     = 1'b1;
                    n_pend_e   = r_rdata;
                    n_pend_off = off[12:0];
                    n_head     = (r_head == mned_pkg::QUEUE_AW'(mned_pkg::QUEUE_DEPTH - 1)) ?
                                 '0 : r_head + 1'b1;
                    n_count    = r_count - 1'b1;
                    n_ntick    = r_ntick + 1'b1;
                    n_state    = S_WAIT;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_entry;
        end
        r_rdata <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b1;
            r_ntick     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
            r_ntick     <= n_ntick;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_len      <= n_len;
        r_pend_e   <= n_pend_e;
        r_pend_off <= n_pend_off;
        r_out_kind <= n_out_kind;
        r_out_off  <= n_out_off;
        r_out_e    <= n_out_e;
        r_out_last <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mned_pkg::CNT_W'(mned_pkg::QUEUE_DEPTH))
        else $error("echo queue count above depth");

    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind) |-> (r_out_last && $past(r_state == S_IDLE)))
        else $error("drop report must be a single last result from idle");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("pending result left behind after drain");

    a_emit_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_kind) |-> $past(r_state == S_CHECK && r_pend))
        else $error("echo result without a pending entry");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !i_q_empty))
        else $error("command popped outside idle");

endmodule
